>>> sv/sha256mh_pkg.sv
// sha256 message hasher: shared types, constants and round functions
// no dependencies; used by the front, back and top level files of the block
package sha256mh_pkg;

    localparam int BlkWords = 16;
    localparam int BlkSlots = 2;
    localparam int RamDepth = BlkWords * BlkSlots;

    // block queue head, front to back
    typedef struct packed {
        logic valid;
        logic slot;
        logic last_blk;
    } t_blk_q;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int n);
        f_rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        f_bsig0 = f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        f_bsig1 = f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        f_ssig0 = f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        f_ssig1 = f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        f_iv = v;
    endfunction

    function automatic logic [31:0] f_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        f_k = k;
    endfunction

endpackage

>>> sv/sha256mh_intf.sv
// sha256 message hasher: request channel interfaces (valid/ready)
// no dependencies
interface sha256mh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;
    modport source (output valid, digest_word, digest_index, last_word, input ready);
    modport sink (input valid, digest_word, digest_index, last_word, output ready);
endinterface

>>> sv/sha256mh_ram.sv
// sha256 message hasher: generic single write, single read ram
// registered read data; no dependencies
module sha256mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/sha256mh_front.sv
// sha256 message hasher front: byte packing, padding, length, block queue
// depends on sha256mh_pkg and sha256mh_intf
module sha256mh_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sha256mh_in_if.sink           i_in,
    input  logic                  i_pop,
    output sha256mh_pkg::t_blk_q  o_q,
    output logic                  o_we,
    output logic [4:0]            o_waddr,
    output logic [31:0]           o_wdata
);
    localparam logic ST_DATA = 1'b0;
    localparam logic ST_PAD  = 1'b1;

    logic        r_state, n_state;
    logic [5:0]  r_fill;
    logic [23:0] r_word;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_len;
    logic        r_first, r_lenph;
    logic        r_wslot, r_rslot;
    logic [1:0]  r_count;
    logic [1:0]  r_last;
    logic        w_space, w_acc, w_have, w_push, w_lenbyte;
    logic [7:0]  w_byte;
    logic [63:0] w_lsh;

    assign w_space   = (r_count != 2'd2);
    assign i_in.ready = (r_state == ST_DATA) && w_space;
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_lenbyte = !r_first && (r_lenph || (r_fill == 6'd56));
    assign w_lsh     = r_len << {r_fill[2:0], 3'b000};

    always_comb begin
        if (r_state == ST_DATA) begin
            w_have = w_acc && i_in.byte_present;
            w_byte = i_in.msg_byte;
        end else begin
            w_have = w_space;
            if (r_first) begin
                w_byte = 8'h80;
            end else if (w_lenbyte) begin
                w_byte = w_lsh[63:56];
            end else begin
                w_byte = 8'h00;
            end
        end
    end

    assign w_push  = w_have && (r_fill == 6'd63);
    assign o_we    = w_have && (r_fill[1:0] == 2'b11);
    assign o_waddr = {r_wslot, r_fill[5:2]};
    assign o_wdata = {r_word, w_byte};

    assign n_bits = r_bits + (w_have ? 64'd8 : 64'd0);

    always_comb begin
        n_state = r_state;
        if (r_state == ST_DATA) begin
            if (w_acc && i_in.end_of_message) begin
                n_state = ST_PAD;
            end
        end else if (w_push && w_lenbyte) begin
            n_state = ST_DATA;
        end
    end

    assign o_q.valid    = (r_count != 2'd0);
    assign o_q.slot     = r_rslot;
    assign o_q.last_blk = r_last[r_rslot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DATA;
            r_fill  <= '0;
            r_bits  <= '0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_wslot <= 1'b0;
            r_rslot <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
            if (i_pop) begin
                r_rslot <= ~r_rslot;
            end
            if (w_push) begin
                r_wslot <= ~r_wslot;
            end
            if (w_have) begin
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == ST_DATA) begin
                if (w_acc && i_in.end_of_message) begin
                    r_bits  <= '0;
                    r_first <= 1'b1;
                end else begin
                    r_bits <= n_bits;
                end
            end else if (w_have) begin
                r_first <= 1'b0;
                r_lenph <= w_lenbyte && !w_push;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_have) begin
            r_word <= {r_word[15:0], w_byte};
        end
        if (w_push) begin
            r_last[r_wslot] <= (r_state == ST_PAD) && w_lenbyte;
        end
        if (r_state == ST_DATA && w_acc && i_in.end_of_message) begin
            r_len <= n_bits;
        end
    end
endmodule

>>> sv/sha256mh_back.sv
// sha256 message hasher back: 64-round compression, chaining, digest output
// depends on sha256mh_pkg and sha256mh_intf
module sha256mh_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256mh_pkg::t_blk_q  i_q,
    output logic                  o_pop,
    output logic [4:0]            o_raddr,
    input  logic [31:0]           i_rdata,
    sha256mh_out_if.source        o_out
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [6:0]  r_cnt;
    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] r_wt;
    logic        r_ovalid;
    logic [2:0]  r_oidx;
    logic [31:0] w_sched, w_cur, w_t1, w_t2;
    logic [5:0]  w_rnd;
    logic [3:0]  w_next;

    assign w_sched = sha256mh_pkg::f_ssig1(r_w[14]) + r_w[9]
                   + sha256mh_pkg::f_ssig0(r_w[1]) + r_w[0];
    assign w_cur   = (r_cnt < 7'd16) ? i_rdata : w_sched;
    assign w_rnd   = 6'(r_cnt - 7'd1);
    assign w_t1    = r_v[7] + sha256mh_pkg::f_bsig1(r_v[4])
                   + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                   + sha256mh_pkg::f_k(w_rnd) + r_wt;
    assign w_t2    = sha256mh_pkg::f_bsig0(r_v[0])
                   + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next  = r_cnt[3:0] + 4'd1;

    assign o_raddr = {i_q.slot, (r_state == ST_RUN) ? w_next : 4'd0};
    assign o_pop   = (r_state == ST_ADD);

    assign o_out.valid        = r_ovalid;
    assign o_out.digest_word  = r_chain[r_oidx];
    assign o_out.digest_index = r_oidx;
    assign o_out.last_word    = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha256mh_pkg::f_iv(3'(i));
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd64) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    if (i_q.last_blk) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                        r_state  <= ST_OUT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_state  <= ST_IDLE;
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= sha256mh_pkg::f_iv(3'(i));
                            end
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // working variables and schedule window, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_state == ST_RUN) begin
            if (r_cnt < 7'd64) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_cur;
                r_wt    <= w_cur;
            end
            if (r_cnt != 7'd0) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
        end
    end
endmodule

>>> sv/sha256_message_hasher_unit.sv
// sha256 message hasher top level: front, block ram, back
// a block enters the chaining words in the back's add state, after its load and run states
// throughput: one byte a cycle while a ram slot is free and the front is not padding;
// compression in the single round unit sets the sustained rate
// end of message: the front appends 0x80, zero bytes and the 64-bit bit length, waiting for a free slot,
// then eight digest words; reset: synchronous active low, chaining words to initial values
module sha256_message_hasher_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha256mh_in_if.sink     i_in,
    sha256mh_out_if.source  o_out
);
    sha256mh_pkg::t_blk_q w_q;
    logic        w_pop;
    logic        w_we;
    logic [4:0]  w_waddr, w_raddr;
    logic [31:0] w_wdata, w_rdata;

    // front packs bytes into words, pads at message end, queues full blocks
    sha256mh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_q     (w_q),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata)
    );

    // two block slots of sixteen words, double buffering between the halves
    sha256mh_ram #(
        .WIDTH (32),
        .DEPTH (sha256mh_pkg::RamDepth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // back runs one round a cycle and hands out the digest
    sha256mh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata),
        .o_out   (o_out)
    );

    // queue never pops empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.valid)
        else $error("block queue popped while empty");

    // no write into a slot the back still owns
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q.valid && w_q.slot == w_waddr[4] && w_we) |-> (u_front.r_count != 2'd2))
        else $error("write into an occupied block slot");

    // digest ends cleanly after its last word
    a_digest_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> !o_out.valid)
        else $error("output still valid after last digest word");
endmodule
